FILE: sv/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg: shared types and helpers for the URL percent decoder
// Word types of both channels, the decode command passed from the front end
// to the back end, escape phase codes and hex digit helpers.
// ----------------------------------------------------------------------------
package upd_pkg;

	// character codes
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_D0    = 8'h30;
	localparam logic [7:0] CH_D9    = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] HEX_TEN  = 8'd10;

	// command queue geometry
	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	// bytes carried by one command
	localparam int CMD_BYTES = 3;

	typedef struct packed {
		logic [7:0] in_char;
		logic       in_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_word_t;

	// escape phase
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	// one decode command: up to three bytes, last flag on the final one
	typedef struct packed {
		logic [1:0]                cnt;
		logic [CMD_BYTES-1:0][7:0] data;
		logic                      last;
	} cmd_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= CH_D0 && c <= CH_D9) || (c >= CH_UA && c <= CH_UF) ||
		       (c >= CH_LA && c <= CH_LF);
	endfunction

	// value of a hex digit; only meaningful when is_hex holds
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] t;
		if (c >= CH_LA) begin
			t = c - CH_LA + HEX_TEN;
		end else if (c >= CH_UA) begin
			t = c - CH_UA + HEX_TEN;
		end else begin
			t = c - CH_D0;
		end
		return t[3:0];
	endfunction

endpackage

FILE: sv/upd_front.sv
// ----------------------------------------------------------------------------
// upd_front: character classifier and escape tracker
// Takes one encoded character per accepted word, tracks the escape phase and
// turns each character into a command of up to three output bytes.
// ----------------------------------------------------------------------------
module upd_front import upd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_word_t item,
	output logic     cmd_push,
	output cmd_t     cmd
);

	phase_t     phase_q, phase_mid, phase_d;
	logic [7:0] held_q, held_mid;
	logic [7:0] c;
	logic       hex;

	assign c   = item.in_char;
	assign hex = is_hex(c);

	// next state: phase after the character, then end-of-string return
	always_comb begin
		case (phase_q)
			PH_PCT: begin
				if (hex) begin
					phase_mid = PH_DIGIT;
				end else begin
					phase_mid = (c == CH_PCT) ? PH_PCT : PH_IDLE;
				end
			end
			PH_DIGIT: begin
				if (hex) begin
					phase_mid = PH_IDLE;
				end else begin
					phase_mid = (c == CH_PCT) ? PH_PCT : PH_IDLE;
				end
			end
			default: begin
				phase_mid = (c == CH_PCT) ? PH_PCT : PH_IDLE;
			end
		endcase
		held_mid = (phase_q == PH_PCT && hex) ? c : held_q;
		phase_d  = item.in_last ? PH_IDLE : phase_mid;
	end

	// outputs: bytes emitted for this character
	always_comb begin
		logic [1:0]                n;
		logic [CMD_BYTES-1:0][7:0] d;
		logic                      do_idle;
		n       = 2'd0;
		d       = '0;
		do_idle = 1'b0;
		case (phase_q)
			PH_PCT: begin
				if (!hex) begin
					d[n]    = CH_PCT;
					n       = n + 2'd1;
					do_idle = 1'b1;
				end
			end
			PH_DIGIT: begin
				if (hex) begin
					d[n] = {hex_val(held_q), hex_val(c)};
					n    = n + 2'd1;
				end else begin
					d[n]    = CH_PCT;
					n       = n + 2'd1;
					d[n]    = held_q;
					n       = n + 2'd1;
					do_idle = 1'b1;
				end
			end
			default: begin
				do_idle = 1'b1;
			end
		endcase
		// plain character handling; a new '%' only opens an escape
		if (do_idle && c != CH_PCT) begin
			d[n] = (c == CH_PLUS) ? CH_SPACE : c;
			n    = n + 2'd1;
		end
		// end of string flushes a pending escape literally
		if (item.in_last) begin
			if (phase_mid == PH_PCT) begin
				d[n] = CH_PCT;
				n    = n + 2'd1;
			end else if (phase_mid == PH_DIGIT) begin
				d[n] = CH_PCT;
				n    = n + 2'd1;
				d[n] = held_mid;
				n    = n + 2'd1;
			end
		end
		cmd.cnt  = n;
		cmd.data = d;
		cmd.last = item.in_last;
		cmd_push = accept && (n != 2'd0);
	end

	// phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (accept) begin
			phase_q <= phase_d;
		end
	end

	// held digit, read only in the digit phase
	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= held_mid;
		end
	end

endmodule

FILE: sv/upd_cmd_queue.sv
// ----------------------------------------------------------------------------
// upd_cmd_queue: command queue between front and back end
// Small first-word-fall-through queue of decode commands; push and pop may
// happen in the same cycle.
// ----------------------------------------------------------------------------
module upd_cmd_queue import upd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic head_valid
);

	cmd_t                 mem_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_q, rd_q;
	logic [CMD_CNT_W-1:0] cnt_q;
	logic                 do_push, do_pop;

	assign full       = (cnt_q == CMD_CNT_W'(CMD_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wr_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + CMD_PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + CMD_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CMD_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CMD_CNT_W'(1);
			end
		end
	end

endmodule

FILE: sv/upd_back.sv
// ----------------------------------------------------------------------------
// upd_back: byte serialiser and output register
// Walks the bytes of the head command into the output word register, one per
// cycle while the consumer pops; the register is held until the consumer pops it.
// ----------------------------------------------------------------------------
module upd_back import upd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      head,
	input  logic      head_valid,
	output logic      head_pop,
	input  logic      pop,
	output logic      empty,
	output out_word_t result
);

	out_word_t  out_q;
	logic       out_valid_q;
	logic [1:0] sel_q;
	logic       load, final_byte;

	assign empty      = !out_valid_q;
	assign result     = out_q;
	assign final_byte = (sel_q == head.cnt - 2'd1);
	assign load       = head_valid && (!out_valid_q || pop);
	assign head_pop   = load && final_byte;

	// output word payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte <= head.data[sel_q];
			out_q.out_last <= head.last && final_byte;
		end
	end

	// byte select and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				sel_q       <= final_byte ? 2'd0 : sel_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder: streaming URL percent decoder
// Path: a decoded byte passes through the command queue and then the output
//   register before it is on the result ports.
// Throughput: one character per cycle while full is low, one byte per cycle
//   while result is popped; a character yielding several bytes is drained
//   by the serialiser; full rises when the four-entry command queue fills.
// Reset: arst_n clears the escape phase, the queue and the output valid.
// ----------------------------------------------------------------------------
module url_percent_decoder import upd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_word_t  item,
	output logic      empty,
	input  logic      pop,
	output out_word_t result
);

	logic accept;
	logic cmd_push, head_valid, head_pop;
	cmd_t cmd, head;

	assign accept = push && !full;

	// front end: classify characters
	upd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.cmd_push (cmd_push),
		.cmd      (cmd)
	);

	// command queue
	upd_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.wr_cmd     (cmd),
		.full       (full),
		.pop        (head_pop),
		.head       (head),
		.head_valid (head_valid)
	);

	// back end: emit bytes
	upd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

endmodule
